[hw/rtl/sbhc_pkg.sv]
// Shared constants, codes and types of the stepper bar height controller.
`timescale 1ns / 1ps

package sbhc_pkg;

	// Number of bars in the installation and width of the position counter.
	localparam int BAR_COUNT = 16;
	localparam int POS_BITS  = 16;

	// 100 < 2^7, so the scaled position fits in POS_BITS + 7 bits.
	localparam int DIV_W     = POS_BITS + 7;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REVERSE      = 2'd0,
		CFG_BAR_INDEX    = 2'd1,
		CFG_SWING_PERIOD = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_SET     = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		MODE_PERCENT  = 2'd0,
		MODE_SWING    = 2'd1,
		MODE_VIBRATE  = 2'd2,
		MODE_IMMOBILE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_POS  = 2'd1,
		STEP_NEG  = 2'd2
	} step_t;

	typedef enum logic [1:0] {
		PH_SEEK_BOTTOM = 2'd0,
		PH_SEEK_TOP    = 2'd1,
		PH_RETURN      = 2'd2,
		PH_DONE        = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EXEC
	} ctl_state_t;

	typedef struct packed {
		logic                start;
		logic [DIV_W-1:0]    dividend;
		logic [POS_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

[hw/rtl/sbhc_if.sv]
// Word channels of the stepper bar height controller: command in, status out.
`timescale 1ns / 1ps

interface sbhc_cmd_if;
	logic              valid;
	logic              ready;
	logic [1:0]        opcode;
	logic [31:0]       now_ms;
	logic              bottom_pressed;
	logic              top_pressed;
	logic              voice_pressed;
	logic [1:0]        order_mode;
	logic signed [8:0] order_percent;

	modport source (
		output valid, opcode, now_ms, bottom_pressed, top_pressed, voice_pressed,
			order_mode, order_percent,
		input ready
	);
	modport sink (
		input valid, opcode, now_ms, bottom_pressed, top_pressed, voice_pressed,
			order_mode, order_percent,
		output ready
	);
endinterface

interface sbhc_status_if;
	logic              valid;
	logic              ready;
	logic [1:0]        step_cmd;
	logic              power_on;
	logic              moving;
	logic              calibrated;
	logic signed [7:0] height_pct;
	logic              voice_event;
	logic [7:0]        voice_code;

	modport source (
		output valid, step_cmd, power_on, moving, calibrated, height_pct, voice_event,
			voice_code,
		input ready
	);
	modport sink (
		input valid, step_cmd, power_on, moving, calibrated, height_pct, voice_event,
			voice_code,
		output ready
	);
endinterface

[hw/rtl/sbhc_div.sv]
// Restoring bit-serial divider for the height percent, one quotient bit per cycle.
`timescale 1ns / 1ps

module sbhc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  sbhc_pkg::div_req_t  req,
	output sbhc_pkg::div_rsp_t  rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [sbhc_pkg::DIV_CNT_W-1:0]      count_q;
	logic [sbhc_pkg::DIV_W-1:0]          quo_q;
	logic [sbhc_pkg::POS_BITS-1:0]       rem_q;
	logic [sbhc_pkg::POS_BITS-1:0]       dvsr_q;

	logic [sbhc_pkg::POS_BITS:0]         shifted;
	logic [sbhc_pkg::POS_BITS:0]         diff;
	logic                                ge;

	// The partial remainder stays below the divisor, so the shifted value
	// stays below twice the divisor and one subtract settles each bit.
	assign shifted = {rem_q, quo_q[sbhc_pkg::DIV_W-1]};
	assign diff    = shifted - {1'b0, dvsr_q};
	assign ge      = (shifted >= {1'b0, dvsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				count_q <= count_q + 1'b1;
				if (count_q == sbhc_pkg::DIV_CNT_W'(sbhc_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.dividend;
			rem_q  <= '0;
			dvsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[sbhc_pkg::POS_BITS-1:0] : shifted[sbhc_pkg::POS_BITS-1:0];
			quo_q <= {quo_q[sbhc_pkg::DIV_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[hw/rtl/stepper_bar_height_controller.sv]
// Top level of the stepper bar height controller: sequencer, state and result register.
// A calibrated control tick starts the height divider on acceptance, waits in ST_DIV for its
// answer, then executes and writes the result register; every other word goes from
// acceptance straight to execution. Execution waits while the result register is full,
// and the next word is taken only once the sequencer is back in idle.
// Reset (arst_n low, asynchronous) returns the bar to homing from the bottom switch,
// with motor power on, percent mode, swing period 500 ms and no result pending.
`timescale 1ns / 1ps

module stepper_bar_height_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	sbhc_cmd_if.sink                             cmd,
	sbhc_status_if.source                        status,
	input  logic                                 cfg_we,
	input  logic [sbhc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sbhc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int PB = sbhc_pkg::POS_BITS;

	// Configuration registers.
	logic        rev_q;
	logic [3:0]  bar_idx_q;
	logic [15:0] period_q;

	// Controller state.
	sbhc_pkg::ctl_state_t state_q, state_d;
	sbhc_pkg::phase_t     phase_q, phase_d;
	sbhc_pkg::mode_t      mode_q, mode_d;
	logic [PB-1:0]        pos_q, pos_d;
	logic [PB-1:0]        span_q, span_d;
	logic [7:0]           height_q, height_d;
	logic [6:0]           target_q, target_d;
	logic                 swing_act_q, swing_act_d;
	logic                 osc_dir_q, osc_dir_d;
	logic [31:0]          origin_q, origin_d;
	logic                 voice_held_q, voice_held_d;
	logic                 power_q, power_d;

	// Captured command word.
	sbhc_pkg::op_t        op_q;
	logic [31:0]          now_q;
	logic                 bot_q;
	logic                 top_q;
	logic                 voice_q;
	logic [1:0]           omode_q;
	logic signed [8:0]    opct_q;

	// Result register.
	logic                 out_valid_q;
	sbhc_pkg::step_t      out_step_q;
	logic                 out_power_q;
	logic                 out_moving_q;
	logic                 out_calib_q;
	logic [7:0]           out_height_q;
	logic                 out_vev_q;
	logic [7:0]           out_vcode_q;

	// Sequencer controls.
	logic                 cmd_ready;
	logic                 accept;
	logic                 need_div;
	logic                 exec_fire;

	// Divider link.
	sbhc_pkg::div_req_t   div_req;
	sbhc_pkg::div_rsp_t   div_rsp;

	// Per-word combinational results.
	sbhc_pkg::step_t      step_d;
	logic                 moving_d;
	logic                 vev_d;
	logic [7:0]           vcode_d;

	logic [PB-1:0]                 pos_mag;
	logic [sbhc_pkg::DIV_W-1:0]    scaled;
	logic [7:0]                    h_calc;
	logic [PB-1:0]                 pos_up;
	logic [PB-1:0]                 pos_dn;
	sbhc_pkg::step_t               code_up;
	sbhc_pkg::step_t               code_dn;
	logic [6:0]                    clamp_pct;
	logic                          swing_due;
	logic [8:0]                    vcode_wide;

	//------------------------------------------------------------------
	// Configuration writes. Index three has no register and is dropped.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q     <= 1'b0;
			bar_idx_q <= 4'd0;
			period_q  <= 16'd500;
		end else if (cfg_we) begin
			case (sbhc_pkg::cfg_reg_t'(cfg_index))
				sbhc_pkg::CFG_REVERSE:      rev_q     <= cfg_wdata[0];
				sbhc_pkg::CFG_BAR_INDEX:    bar_idx_q <= cfg_wdata[3:0];
				sbhc_pkg::CFG_SWING_PERIOD: period_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Sequencer. A calibrated control tick needs the height of the
	// position before this tick's step, so the divider is started on the
	// acceptance edge from the stored position and span.
	//------------------------------------------------------------------
	assign need_div = (sbhc_pkg::op_t'(cmd.opcode) == sbhc_pkg::OP_TICK) &&
		(phase_q == sbhc_pkg::PH_DONE) && (span_q != '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			sbhc_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = need_div ? sbhc_pkg::ST_DIV : sbhc_pkg::ST_EXEC;
				end
			end
			sbhc_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = sbhc_pkg::ST_EXEC;
				end
			end
			sbhc_pkg::ST_EXEC: begin
				if (exec_fire) begin
					state_d = sbhc_pkg::ST_IDLE;
				end
			end
			default: state_d = sbhc_pkg::ST_IDLE;
		endcase
	end

	// The update is committed only when the result register can take the
	// word, which keeps a stalled consumer from losing a result.
	always_comb begin
		cmd_ready = (state_q == sbhc_pkg::ST_IDLE);
		exec_fire = (state_q == sbhc_pkg::ST_EXEC) && (!out_valid_q || status.ready);
	end

	assign cmd.ready = cmd_ready;
	assign accept    = cmd.valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbhc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= sbhc_pkg::op_t'(cmd.opcode);
			now_q   <= cmd.now_ms;
			bot_q   <= cmd.bottom_pressed;
			top_q   <= cmd.top_pressed;
			voice_q <= cmd.voice_pressed;
			omode_q <= cmd.order_mode;
			opct_q  <= cmd.order_percent;
		end
	end

	//------------------------------------------------------------------
	// Height divider: |position| * 100 / span, the sign handled outside.
	// The magnitude of the most negative position still fits unsigned.
	//------------------------------------------------------------------
	assign pos_mag = pos_q[PB-1] ? (~pos_q + 1'b1) : pos_q;
	assign scaled  = (sbhc_pkg::DIV_W'(pos_mag) << 6) + (sbhc_pkg::DIV_W'(pos_mag) << 5) +
		(sbhc_pkg::DIV_W'(pos_mag) << 2);

	assign div_req.start    = accept && need_div;
	assign div_req.dividend = scaled;
	assign div_req.divisor  = span_q;

	sbhc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Truncated quotient saturated to a signed byte; a zero span reads as zero.
	always_comb begin
		h_calc = 8'd0;
		if (span_q != '0) begin
			if (!pos_q[PB-1]) begin
				h_calc = (div_rsp.quotient > sbhc_pkg::DIV_W'(127)) ? 8'd127 :
					div_rsp.quotient[7:0];
			end else begin
				h_calc = (div_rsp.quotient > sbhc_pkg::DIV_W'(128)) ? 8'h80 :
					(~div_rsp.quotient[7:0] + 8'd1);
			end
		end
	end

	//------------------------------------------------------------------
	// Word execution.
	//------------------------------------------------------------------
	assign pos_up  = pos_q + 1'b1;
	assign pos_dn  = pos_q - 1'b1;
	assign code_up = rev_q ? sbhc_pkg::STEP_NEG : sbhc_pkg::STEP_POS;
	assign code_dn = rev_q ? sbhc_pkg::STEP_POS : sbhc_pkg::STEP_NEG;

	always_comb begin
		if (opct_q > 9'sd100) begin
			clamp_pct = 7'd100;
		end else if (opct_q < 9'sd0) begin
			clamp_pct = 7'd0;
		end else begin
			clamp_pct = opct_q[6:0];
		end
	end

	// The swing deadline is compared in 33 bits so that it never wraps.
	assign swing_due  = {1'b0, now_q} > ({1'b0, origin_q} + {17'd0, period_q});
	assign vcode_wide = 9'(sbhc_pkg::BAR_COUNT) - {5'd0, bar_idx_q} - 9'd1;

	always_comb begin
		phase_d      = phase_q;
		mode_d       = mode_q;
		pos_d        = pos_q;
		span_d       = span_q;
		height_d     = height_q;
		target_d     = target_q;
		swing_act_d  = swing_act_q;
		osc_dir_d    = osc_dir_q;
		origin_d     = origin_q;
		voice_held_d = voice_held_q;
		power_d      = power_q;
		step_d       = sbhc_pkg::STEP_NONE;
		moving_d     = 1'b0;
		vev_d        = 1'b0;
		vcode_d      = 8'd0;

		case (op_q)
			sbhc_pkg::OP_SET: begin
				mode_d = sbhc_pkg::mode_t'(omode_q);
				if (sbhc_pkg::mode_t'(omode_q) == sbhc_pkg::MODE_PERCENT) begin
					target_d = clamp_pct;
				end
			end
			sbhc_pkg::OP_RESTART: begin
				phase_d = sbhc_pkg::PH_SEEK_BOTTOM;
				pos_d   = '0;
				span_d  = '0;
				power_d = 1'b1;
			end
			sbhc_pkg::OP_TICK: begin
				case (phase_q)
					sbhc_pkg::PH_SEEK_BOTTOM: begin
						step_d = code_dn;
						pos_d  = pos_dn;
						if (bot_q) begin
							phase_d = sbhc_pkg::PH_SEEK_TOP;
						end
					end
					sbhc_pkg::PH_SEEK_TOP: begin
						step_d = code_up;
						pos_d  = pos_up;
						if (span_q != '1) begin
							span_d = span_q + 1'b1;
						end
						if (top_q) begin
							phase_d = sbhc_pkg::PH_RETURN;
						end
					end
					sbhc_pkg::PH_RETURN: begin
						step_d = code_dn;
						pos_d  = pos_dn;
						// At the bottom the position is zeroed, so the height is zero.
						if (bot_q) begin
							phase_d  = sbhc_pkg::PH_DONE;
							pos_d    = '0;
							height_d = 8'd0;
							power_d  = 1'b0;
						end
					end
					default: begin
						height_d = h_calc;
						case (mode_q)
							sbhc_pkg::MODE_SWING: begin
								power_d = 1'b1;
								step_d  = osc_dir_q ? code_dn : code_up;
								pos_d   = osc_dir_q ? pos_dn : pos_up;
								if (!swing_act_q) begin
									// A fresh swing starts its period now and
									// cannot be due on the same tick.
									swing_act_d = 1'b1;
									origin_d    = now_q;
								end else if (swing_due) begin
									origin_d  = now_q;
									osc_dir_d = ~osc_dir_q;
								end
							end
							sbhc_pkg::MODE_VIBRATE: begin
								power_d     = 1'b1;
								step_d      = osc_dir_q ? code_dn : code_up;
								pos_d       = osc_dir_q ? pos_dn : pos_up;
								osc_dir_d   = ~osc_dir_q;
								swing_act_d = 1'b0;
							end
							sbhc_pkg::MODE_IMMOBILE: begin
								power_d     = 1'b0;
								swing_act_d = 1'b0;
							end
							default: begin
								if (($signed(h_calc) > $signed({1'b0, target_q})) && !bot_q) begin
									power_d  = 1'b1;
									step_d   = code_dn;
									pos_d    = pos_dn;
									moving_d = 1'b1;
								end else if (($signed(h_calc) < $signed({1'b0, target_q})) &&
									!top_q) begin
									power_d  = 1'b1;
									step_d   = code_up;
									pos_d    = pos_up;
									moving_d = 1'b1;
								end else begin
									power_d = 1'b0;
								end
							end
						endcase
						// One event per press of the voice button.
						if (voice_q) begin
							if (!voice_held_q) begin
								voice_held_d = 1'b1;
								vev_d        = 1'b1;
								vcode_d      = vcode_wide[7:0];
							end
						end else begin
							voice_held_d = 1'b0;
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= sbhc_pkg::PH_SEEK_BOTTOM;
			mode_q       <= sbhc_pkg::MODE_PERCENT;
			pos_q        <= '0;
			span_q       <= '0;
			height_q     <= 8'd0;
			target_q     <= 7'd0;
			swing_act_q  <= 1'b0;
			osc_dir_q    <= 1'b0;
			origin_q     <= 32'd0;
			voice_held_q <= 1'b0;
			power_q      <= 1'b1;
		end else if (exec_fire) begin
			phase_q      <= phase_d;
			mode_q       <= mode_d;
			pos_q        <= pos_d;
			span_q       <= span_d;
			height_q     <= height_d;
			target_q     <= target_d;
			swing_act_q  <= swing_act_d;
			osc_dir_q    <= osc_dir_d;
			origin_q     <= origin_d;
			voice_held_q <= voice_held_d;
			power_q      <= power_d;
		end
	end

	//------------------------------------------------------------------
	// Result register: holds one word until the consumer takes it.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			out_step_q   <= step_d;
			out_power_q  <= power_d;
			out_moving_q <= moving_d;
			out_calib_q  <= (phase_d == sbhc_pkg::PH_DONE);
			out_height_q <= height_d;
			out_vev_q    <= vev_d;
			out_vcode_q  <= vcode_d;
		end
	end

	assign status.valid       = out_valid_q;
	assign status.step_cmd    = out_step_q;
	assign status.power_on    = out_power_q;
	assign status.moving      = out_moving_q;
	assign status.calibrated  = out_calib_q;
	assign status.height_pct  = out_height_q;
	assign status.voice_event = out_vev_q;
	assign status.voice_code  = out_vcode_q;

	//------------------------------------------------------------------
	// Assertions.
	//------------------------------------------------------------------

	// Finishing homing always counts at least one step of span.
	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sbhc_pkg::PH_DONE) |-> (span_q != '0))
		else $error("calibrated with a zero span");

	// Regulation and voice events only happen once the bar is calibrated.
	a_uncal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(status.valid && !status.calibrated) |-> (!status.moving && !status.voice_event))
		else $error("regulation output before calibration");

	// A regulated move always carries a motor step.
	a_moving_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(status.valid && status.moving) |->
			(status.step_cmd == sbhc_pkg::STEP_POS || status.step_cmd == sbhc_pkg::STEP_NEG))
		else $error("moving without a step");

	// The divider answer leads straight to execution of the word.
	a_div_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbhc_pkg::ST_DIV && div_rsp.done) |=> (state_q == sbhc_pkg::ST_EXEC))
		else $error("divider result not taken");

	// The divider is only started while no word is in progress.
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (state_q == sbhc_pkg::ST_IDLE))
		else $error("divider started during a word");

endmodule
